// File: rtl/core/fdsi_pkg.sv
// Shared types and constants for the finite-difference / Simpson integrator.
package fdsi_pkg;

    localparam int DATA_W      = 32;
    localparam int IDX_W       = 10;
    localparam int ERR_W       = 31;
    localparam int WSUM_W      = 64;
    localparam int OUT_TDATA_W = 144;

    // Configuration register indexes
    localparam logic [1:0] CFG_INVERSE_STEP = 2'd0;
    localparam logic [1:0] CFG_STEP_THIRD   = 2'd1;

    localparam logic [DATA_W-1:0] INVERSE_STEP_RST = 32'd65536;
    localparam logic [DATA_W-1:0] STEP_THIRD_RST   = 32'd21845;

    // Difference methods
    localparam logic [1:0] METHOD_FORWARD  = 2'd0;
    localparam logic [1:0] METHOD_CENTERED = 2'd1;
    localparam logic [1:0] METHOD_BACKWARD = 2'd2;

    // Set status
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ODD      = 2'd1;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd2;

    typedef struct packed {
        logic                     start;
        logic                     centered;
        logic signed [WSUM_W-1:0] operand;
        logic [DATA_W-1:0]        mult;
    } t_mul_req;

    typedef struct packed {
        logic [IDX_W-1:0]         point_index;
        logic signed [DATA_W-1:0] derivative;
        logic [1:0]               method;
        logic                     last_result;
        logic signed [DATA_W-1:0] simpson_integral;
        logic signed [DATA_W-1:0] exact_integral;
        logic [ERR_W-1:0]         absolute_error;
        logic [1:0]               status;
    } t_result;

endpackage

// File: rtl/core/finite_difference_simpson_integrator.sv
// Top level: sample sequencer, set state, result register and config registers.
//
//  channel | direction | handshake                 | payload
//  s       | in        | i_s_tvalid / o_s_tready   | i_s_tdata (sample), i_s_tlast
//  m       | out       | o_m_tvalid / i_m_tready   | o_m_tdata, o_m_tuser (method), o_m_tlast
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The first sample of a set is only stored, unless it is also the last. Each later sample
// takes one scaling, and the last one needs two more. Each scaling holds the shared 32x32
// multiplier for two partial products plus round/saturate. A full output register
// stalls the sequencer in its emit states only.
// Synchronous active-low reset; no clearing pass.
module finite_difference_simpson_integrator
    import fdsi_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,   // [31:0] sample
    input  logic                   i_s_tlast,   // last_sample
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [9:0] point_index, [41:10] derivative, [73:42] simpson_integral,
    // [105:74] exact_integral, [136:106] absolute_error, [138:137] status, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]             o_m_tuser,   // [1:0] method
    output logic                   o_m_tlast,   // last_result
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [DATA_W-1:0]      i_cfg_data
);

    localparam int PW = $clog2(MAX_POINTS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_D1   = 4'd1;
    localparam logic [3:0] S_W1   = 4'd2;
    localparam logic [3:0] S_E1   = 4'd3;
    localparam logic [3:0] S_D2   = 4'd4;
    localparam logic [3:0] S_W2   = 4'd5;
    localparam logic [3:0] S_SI   = 4'd6;
    localparam logic [3:0] S_W3   = 4'd7;
    localparam logic [3:0] S_E2   = 4'd8;

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [DATA_W-1:0]        r_inv_step;
    logic [DATA_W-1:0]        r_step_third;
    logic signed [DATA_W-1:0] r_cur;
    logic                     r_last;
    logic signed [DATA_W-1:0] r_older;
    logic signed [DATA_W-1:0] r_newer;
    logic signed [DATA_W-1:0] r_first;
    logic [PW-1:0]            r_pts;
    logic signed [WSUM_W-1:0] r_ws;
    logic signed [DATA_W-1:0] r_db;
    logic signed [DATA_W-1:0] r_exact;
    t_result                  r_pend;
    t_result                  r_out;
    logic                     r_out_valid;

    t_mul_req                 mul_req;
    logic                     mul_done;
    logic signed [DATA_W-1:0] mul_result;

    logic                     s_xfer;
    logic                     in_last;
    logic                     slot_free;
    logic signed [WSUM_W-1:0] diff_prev;
    logic signed [WSUM_W-1:0] diff_older;
    logic signed [DATA_W:0]   exact_diff;
    logic signed [DATA_W:0]   err_diff;
    logic [DATA_W:0]          err_abs;
    logic [ERR_W-1:0]         err_sat;
    logic signed [WSUM_W-1:0] mul_ext;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign in_last    = i_s_tlast ||
                        ((PW+1)'(r_pts) + (PW+1)'(1) >= (PW+1)'(MAX_POINTS));
    assign slot_free  = !r_out_valid || i_m_tready;

    assign diff_prev  = {{DATA_W{r_cur[DATA_W-1]}}, r_cur}
                      - {{DATA_W{r_newer[DATA_W-1]}}, r_newer};
    assign diff_older = {{DATA_W{r_cur[DATA_W-1]}}, r_cur}
                      - {{DATA_W{r_older[DATA_W-1]}}, r_older};
    assign exact_diff = {r_cur[DATA_W-1], r_cur} - {r_first[DATA_W-1], r_first};
    assign err_diff   = {mul_result[DATA_W-1], mul_result} - {r_exact[DATA_W-1], r_exact};
    assign err_abs    = err_diff[DATA_W] ? (DATA_W+1)'(-err_diff) : (DATA_W+1)'(err_diff);
    assign err_sat    = (|err_abs[DATA_W:ERR_W]) ? {ERR_W{1'b1}} : err_abs[ERR_W-1:0];
    assign mul_ext    = {{(WSUM_W-DATA_W){mul_result[DATA_W-1]}}, mul_result};

    // Shared unit request
    always_comb begin
        mul_req.start    = (r_state == S_D1) || (r_state == S_D2) || (r_state == S_SI);
        mul_req.centered = (r_state == S_D1) && (r_pts != PW'(1));
        mul_req.mult     = (r_state == S_SI) ? r_step_third : r_inv_step;
        case (r_state)
            S_D1:    mul_req.operand = (r_pts == PW'(1)) ? diff_prev : diff_older;
            S_SI:    mul_req.operand = r_ws;
            default: mul_req.operand = diff_prev;
        endcase
    end

    fdsi_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    if (r_pts != '0) n_state = S_D1;
                    else if (in_last) n_state = S_E2;
                end
            end
            S_D1:    n_state = S_W1;
            S_W1:    if (mul_done) n_state = S_E1;
            S_E1:    if (slot_free) n_state = r_last ? S_D2 : S_IDLE;
            S_D2:    n_state = S_W2;
            S_W2:    if (mul_done) n_state = S_SI;
            S_SI:    n_state = S_W3;
            S_W3:    if (mul_done) n_state = S_E2;
            S_E2:    if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_step   <= INVERSE_STEP_RST;
            r_step_third <= STEP_THIRD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INVERSE_STEP: r_inv_step   <= i_cfg_data;
                CFG_STEP_THIRD:   r_step_third <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_older <= '0;
            r_newer <= '0;
            r_first <= '0;
            r_pts   <= '0;
            r_ws    <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_cur  <= signed'(i_s_tdata);
                        r_last <= in_last;
                        if (r_pts == '0) begin
                            r_first <= signed'(i_s_tdata);
                            r_newer <= signed'(i_s_tdata);
                            if (!in_last) begin
                                r_pts <= PW'(1);
                            end else begin
                                r_pend <= '{point_index: '0, derivative: '0,
                                            method: METHOD_FORWARD, last_result: 1'b1,
                                            simpson_integral: '0, exact_integral: '0,
                                            absolute_error: '0, status: STATUS_TOO_FEW};
                            end
                        end
                    end
                end
                S_W1: begin
                    if (mul_done) begin
                        // Simpson weight: 1 at the first point, then 4, 2, 4, ...
                        if (r_pts == PW'(1)) r_ws <= r_ws + mul_ext;
                        else if (r_pts[0])   r_ws <= r_ws + (mul_ext <<< 1);
                        else                 r_ws <= r_ws + (mul_ext <<< 2);
                        r_pend <= '{point_index: IDX_W'(r_pts - PW'(1)),
                                    derivative: mul_result,
                                    method: (r_pts == PW'(1)) ? METHOD_FORWARD
                                                              : METHOD_CENTERED,
                                    last_result: 1'b0, simpson_integral: '0,
                                    exact_integral: '0, absolute_error: '0,
                                    status: STATUS_OK};
                    end
                end
                S_E1: begin
                    if (slot_free && !r_last) begin
                        r_older <= r_newer;
                        r_newer <= r_cur;
                        r_pts   <= r_pts + PW'(1);
                    end
                end
                S_W2: begin
                    if (mul_done) begin
                        r_ws <= r_ws + mul_ext;
                        r_db <= mul_result;
                    end
                end
                S_SI: begin
                    if (exact_diff[DATA_W] != exact_diff[DATA_W-1]) begin
                        r_exact <= exact_diff[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        r_exact <= exact_diff[DATA_W-1:0];
                    end
                end
                S_W3: begin
                    if (mul_done) begin
                        r_pend <= '{point_index: IDX_W'(r_pts), derivative: r_db,
                                    method: METHOD_BACKWARD, last_result: 1'b1,
                                    simpson_integral: mul_result, exact_integral: r_exact,
                                    absolute_error: err_sat,
                                    status: r_pts[0] ? STATUS_ODD : STATUS_OK};
                    end
                end
                S_E2: begin
                    if (slot_free) begin
                        r_older <= '0;
                        r_newer <= '0;
                        r_first <= '0;
                        r_pts   <= '0;
                        r_ws    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free && ((r_state == S_E1) || (r_state == S_E2))) begin
            r_out_valid <= 1'b1;
            r_out       <= r_pend;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last_result;
    assign o_m_tuser  = r_out.method;
    assign o_m_tdata  = {5'd0, r_out.status, r_out.absolute_error, r_out.exact_integral,
                         r_out.simpson_integral, r_out.derivative, r_out.point_index};

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_W1 || r_state == S_W2 || r_state == S_W3))
        else $error("scaling result arrived outside a wait state");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && r_pts != '0) |=> !o_s_tready)
        else $error("ready while a sample is being processed");

    a_mid_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_result) |->
            (r_out.simpson_integral == '0 && r_out.status == STATUS_OK &&
             r_out.absolute_error == '0))
        else $error("integral fields set on an intermediate result");

    a_too_few_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STATUS_TOO_FEW) |->
            (r_out.last_result && r_out.point_index == '0))
        else $error("too-few status on a result other than a lone point");
`endif

endmodule

// File: rtl/core/fdsi_mul.sv
// Shared scaling unit: |v| * mult over two 32x32 passes, round, shift, saturate.
module fdsi_mul
    import fdsi_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_req                 i_req,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_result
);

    localparam int ACC_W = WSUM_W + DATA_W;

    logic                   r_busy;
    logic [1:0]             r_step;
    logic                   r_neg;
    logic                   r_centered;
    logic [WSUM_W-1:0]      r_mag;
    logic [DATA_W-1:0]      r_mult;
    logic [2*DATA_W-1:0]    r_prod;
    logic [ACC_W-1:0]       r_acc;
    logic                   r_done;
    logic signed [DATA_W-1:0] r_result;

    logic [DATA_W-1:0]      mul_a;
    logic [ACC_W-1:0]       rounded;
    logic [ACC_W-1:0]       quot;
    logic [DATA_W-1:0]      limit;
    logic [DATA_W-1:0]      mag_res;

    assign mul_a = (r_step == 2'd0) ? r_mag[DATA_W-1:0] : r_mag[WSUM_W-1:DATA_W];

    always_comb begin
        if (r_centered) begin
            rounded = r_acc + (ACC_W'(1) << FRACTION_BITS);
            quot    = rounded >> (FRACTION_BITS + 1);
        end else begin
            rounded = r_acc + (ACC_W'(1) << (FRACTION_BITS - 1));
            quot    = rounded >> FRACTION_BITS;
        end
        limit = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if ((|quot[ACC_W-1:DATA_W]) || (quot[DATA_W-1:0] > limit)) begin
            mag_res = limit;
        end else begin
            mag_res = quot[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy     <= 1'b1;
                r_step     <= 2'd0;
                r_neg      <= i_req.operand[WSUM_W-1];
                r_mag      <= i_req.operand[WSUM_W-1] ? WSUM_W'(-i_req.operand)
                                                      : WSUM_W'(i_req.operand);
                r_mult     <= i_req.mult;
                r_centered <= i_req.centered;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                case (r_step)
                    2'd0: begin
                        r_prod <= mul_a * r_mult;
                    end
                    2'd1: begin
                        r_acc  <= {{DATA_W{1'b0}}, r_prod};
                        r_prod <= mul_a * r_mult;
                    end
                    2'd2: begin
                        r_acc <= r_acc + {r_prod, {DATA_W{1'b0}}};
                    end
                    default: begin
                        r_result <= r_neg ? -mag_res : mag_res;
                        r_done   <= 1'b1;
                        r_busy   <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: tb/fdsi_scoreboard_pkg.sv
// Scoreboard for the derivative / Simpson integrator: predicts and checks results.
`timescale 1ns / 100ps

package fdsi_scoreboard_pkg;
    import fdsi_pkg::*;

    localparam int SET_LIMIT = 1024;
    localparam int FRAC_BITS = 16;

    class derivative_integral_scoreboard;
        bit [DATA_W-1:0] inverse_step;
        bit [DATA_W-1:0] step_third;
        longint          older_value;
        longint          newer_value;
        longint          first_value;
        longint          weighted_sum;
        int unsigned     points_in_set;

        t_result         expected_results[$];
        int unsigned     mismatches;
        int unsigned     results_checked;
        int unsigned     samples_seen;
        int unsigned     saturated_slopes;
        int unsigned     sets_by_status[4];

        function new();
            inverse_step = INVERSE_STEP_RST;
            step_third   = STEP_THIRD_RST;
            clear_set();
        endfunction

        function void clear_set();
            older_value   = 0;
            newer_value   = 0;
            first_value   = 0;
            weighted_sum  = 0;
            points_in_set = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void set_register(logic [1:0] index, logic [DATA_W-1:0] value);
            case (index)
                CFG_INVERSE_STEP: inverse_step = value;
                CFG_STEP_THIRD:   step_third   = value;
                default: ;
            endcase
        endfunction

        // v * mult / 2^sh, rounded half away from zero, clamped to the int32 range
        function longint scale_round_sat(longint v, bit [DATA_W-1:0] mult, int unsigned sh);
            bit         neg;
            bit [63:0]  mag;
            bit [127:0] prod;
            bit [127:0] limit;
            neg   = v < 0;
            mag   = neg ? 64'(-v) : 64'(v);
            prod  = ({64'd0, mag} * {96'd0, mult} + (128'd1 << (sh - 1))) >> sh;
            limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (prod > limit) prod = limit;
            return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void push_slope(longint d, int unsigned idx, logic [1:0] method);
            t_result r;
            r = '0;
            r.point_index = idx[IDX_W-1:0];
            r.derivative  = d[DATA_W-1:0];
            r.method      = method;
            if (d == 64'sd2147483647 || d == -64'sd2147483648) saturated_slopes++;
            expected_results.push_back(r);
        endfunction

        // Advance the set state by one accepted sample and queue what it produces.
        function void take_sample(logic [DATA_W-1:0] sample, logic last_flag);
            longint      s;
            longint      prev;
            longint      d;
            longint      simp;
            longint      exact;
            longint      diff;
            bit [63:0]   err;
            bit          closing;
            t_result     r;
            samples_seen++;
            s       = longint'(signed'(sample));
            closing = last_flag || (points_in_set + 1 >= SET_LIMIT);
            prev    = newer_value;

            if (points_in_set == 0) begin
                first_value = s;
                newer_value = s;
                if (!closing) begin
                    points_in_set = 1;
                    return;
                end
                r = '0;
                r.method      = METHOD_FORWARD;
                r.last_result = 1'b1;
                r.status      = STATUS_TOO_FEW;
                expected_results.push_back(r);
                sets_by_status[STATUS_TOO_FEW]++;
                clear_set();
                return;
            end

            if (points_in_set == 1) begin
                d = scale_round_sat(s - prev, inverse_step, FRAC_BITS);
                weighted_sum += d;
                push_slope(d, 0, METHOD_FORWARD);
            end else begin
                d = scale_round_sat(s - older_value, inverse_step, FRAC_BITS + 1);
                // interior weights alternate 4, 2 starting at index 1
                weighted_sum += d * (((points_in_set - 1) & 1) ? 4 : 2);
                push_slope(d, points_in_set - 1, METHOD_CENTERED);
            end
            older_value = prev;
            newer_value = s;

            if (!closing) begin
                points_in_set++;
                return;
            end

            d = scale_round_sat(s - prev, inverse_step, FRAC_BITS);
            weighted_sum += d;
            simp  = scale_round_sat(weighted_sum, step_third, FRAC_BITS);
            exact = clamp32(s - first_value);
            diff  = simp - exact;
            err   = diff < 0 ? 64'(-diff) : 64'(diff);
            if (err > 64'h7FFF_FFFF) err = 64'h7FFF_FFFF;
            if (d == 64'sd2147483647 || d == -64'sd2147483648) saturated_slopes++;
            r = '0;
            r.point_index      = points_in_set[IDX_W-1:0];
            r.derivative       = d[DATA_W-1:0];
            r.method           = METHOD_BACKWARD;
            r.last_result      = 1'b1;
            r.simpson_integral = simp[DATA_W-1:0];
            r.exact_integral   = exact[DATA_W-1:0];
            r.absolute_error   = err[ERR_W-1:0];
            r.status           = (points_in_set & 1) ? STATUS_ODD : STATUS_OK;
            expected_results.push_back(r);
            sets_by_status[r.status]++;
            clear_set();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
        endtask

        task compare_field(string name, logic [9:0] idx, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("point %0d %s got %h want %h", idx, name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                report($sformatf("result for point %0d with nothing outstanding",
                                 got.point_index));
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            compare_field("point_index", want.point_index, got.point_index, want.point_index);
            compare_field("derivative", want.point_index, got.derivative, want.derivative);
            compare_field("method", want.point_index, got.method, want.method);
            compare_field("last_result", want.point_index, got.last_result, want.last_result);
            compare_field("simpson_integral", want.point_index,
                          got.simpson_integral, want.simpson_integral);
            compare_field("exact_integral", want.point_index,
                          got.exact_integral, want.exact_integral);
            compare_field("absolute_error", want.point_index,
                          got.absolute_error, want.absolute_error);
            compare_field("status", want.point_index, got.status, want.status);
        endtask
    endclass

endpackage

// File: tb/finite_difference_simpson_integrator_test.sv
// Top-level testbench: drives sample sets and register writes, checks every result.
`timescale 1ns / 100ps

module finite_difference_simpson_integrator_test;
    import fdsi_pkg::*;
    import fdsi_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_200_000;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned PHASE_SAMPLES = 18;

    typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_SMOOTH, SHAPE_EDGES} t_sample_shape;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [DATA_W-1:0]      i_s_tdata;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [1:0]             o_m_tuser;
    logic                   o_m_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index;
    logic [DATA_W-1:0]      i_cfg_data;

    derivative_integral_scoreboard sb;
    int unsigned samples_taken;
    int unsigned writes_taken;
    int unsigned cycle_count;
    int unsigned hold_request;
    int unsigned sets_sent;
    bit          steady;

    finite_difference_simpson_integrator #(
        .MAX_POINTS    (SET_LIMIT),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    // Sample every transfer at the rising edge; results are checked before new samples land.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = '0;
                got.point_index      = o_m_tdata[9:0];
                got.derivative       = o_m_tdata[41:10];
                got.simpson_integral = o_m_tdata[73:42];
                got.exact_integral   = o_m_tdata[105:74];
                got.absolute_error   = o_m_tdata[136:106];
                got.status           = o_m_tdata[138:137];
                got.method           = o_m_tuser;
                got.last_result      = o_m_tlast;
                sb.check_result(got);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_register(i_cfg_index, i_cfg_data);
                writes_taken++;
            end
            if (i_s_tvalid && o_s_tready) begin
                sb.take_sample(i_s_tdata, i_s_tlast);
                samples_taken++;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random stalls, quiet in steady stretches, long hold on request.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic send_sample(input logic [DATA_W-1:0] value, input logic last_flag);
        int unsigned gap;
        int unsigned seen;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        seen = samples_taken;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last_flag;
        do @(negedge i_clk); while (samples_taken == seen);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
        int unsigned seen;
        seen = writes_taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (writes_taken == seen);
    endtask

    // Drop the input, wait for every outstanding result, then let the block go quiet.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] next_value(t_sample_shape shape,
                                                     logic [DATA_W-1:0] prev);
        case (shape)
            SHAPE_WIDE:   return $urandom;
            SHAPE_NARROW: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            SHAPE_SMOOTH: return prev + ($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic send_set(input int unsigned count, input t_sample_shape shape);
        logic [DATA_W-1:0] v;
        v = $urandom;
        for (int unsigned k = 0; k < count; k++) begin
            v = next_value(shape, v);
            send_sample(v, k == count - 1);
        end
        sets_sent++;
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned len;
        int unsigned r;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tlast    = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_INVERSE_STEP;
        i_cfg_data   = '0;
        hold_request = 0;
        steady       = 1'b0;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single points, two-point sets at full scale, then short clean sets around a four-point full-scale set.
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0004_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0004_0000, 1'b0);
        send_sample(32'h0009_0000, 1'b0);
        send_sample(32'h0010_0000, 1'b1);
        sets_sent += 7;
        settle();

        // Overlong set: closes itself at the size limit, the tail starts a new set.
        send_set(SET_LIMIT + 6, SHAPE_SMOOTH);
        sets_sent++;
        settle();

        for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_INVERSE_STEP, 32'h0000_0000);
                    write_reg(CFG_STEP_THIRD, 32'h0000_0000);
                end
                1: begin
                    write_reg(CFG_INVERSE_STEP, 32'hFFFF_FFFF);
                    write_reg(CFG_STEP_THIRD, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(CFG_INVERSE_STEP, INVERSE_STEP_RST);
                    write_reg(CFG_STEP_THIRD, STEP_THIRD_RST);
                end
                default: begin
                    if (ph & 1) begin
                        write_reg(CFG_STEP_THIRD, $urandom);
                        write_reg(CFG_INVERSE_STEP, $urandom);
                    end else begin
                        write_reg(CFG_INVERSE_STEP, $urandom_range(32'h400, 32'h40_0000));
                        write_reg(CFG_STEP_THIRD, $urandom_range(32'h100, 32'h10_0000));
                    end
                end
            endcase
            i_cfg_valid <= 1'b0;
            @(negedge i_clk);

            // Hold the receiver off long enough to back the block up into its input.
            if (ph == 2 || ph == 5) hold_request = 400;

            phase_start = samples_taken;
            while (samples_taken - phase_start < PHASE_SAMPLES) begin
                steady = ($urandom_range(0, 5) == 0);
                r = $urandom_range(0, 99);
                if (r < 8) len = 1;
                else if (r < 90) len = $urandom_range(2, 12);
                else len = $urandom_range(13, 60);
                send_set(len, t_sample_shape'($urandom_range(0, 3)));
            end
            steady = 1'b0;
            settle();
        end

        $display("ran %0d samples in %0d sets over %0d cycles, %0d results checked, %0d writes",
                 samples_taken, sets_sent, cycle_count, sb.results_checked, writes_taken);
        $display("closed sets: ok %0d, odd %0d, too few %0d; saturated slopes %0d",
                 sb.sets_by_status[STATUS_OK], sb.sets_by_status[STATUS_ODD],
                 sb.sets_by_status[STATUS_TOO_FEW], sb.saturated_slopes);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/fdsi_pkg.sv
rtl/core/fdsi_mul.sv
rtl/core/finite_difference_simpson_integrator.sv
tb/fdsi_scoreboard_pkg.sv
tb/finite_difference_simpson_integrator_test.sv
